### rtl/scs_pkg.sv
// scs_pkg: shared types and constants for the sparse cosine similarity unit
// no dependencies
package scs_pkg;

	localparam int IDX_W = 24;
	localparam int VAL_W = 32;
	localparam int ACC_W = 64;
	localparam int COS_W = 32;

	typedef enum logic [1:0] {
		KIND_A      = 2'd0,
		KIND_B      = 2'd1,
		KIND_FINISH = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [IDX_W-1:0] index;
		logic [VAL_W-1:0] value;
	} in_word_t;

	typedef struct packed {
		logic [ACC_W-1:0] dot_product;
		logic [COS_W-1:0] cosine;
		logic             zero_norm;
		logic             overflow;
		logic             order_error;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_A_SQ,
		ST_B_SQ,
		ST_B_CMP,
		ST_B_MUL,
		ST_FIN_SQA,
		ST_FIN_WA,
		ST_FIN_SQB,
		ST_FIN_WB,
		ST_FIN_MUL,
		ST_FIN_DEN,
		ST_FIN_DIV,
		ST_OUT
	} state_t;

	localparam logic signed [ACC_W-1:0] S64_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] S64_MIN = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic [COS_W-1:0]        COS_ONE = 32'h4000_0000;

endpackage

### rtl/scs_if.sv
// scs_if: valid/ready channel carrying one word
// no dependencies
interface scs_if #(parameter int W = 8) (input logic clk);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/sparse_cosine_similarity_unit.sv
// sparse_cosine_similarity_unit: top level, sequencer, shared multiplier and accumulators
// depends on scs_pkg, scs_if, scs_ram, scs_sqrt, scs_div
//
// in: words of kind, index, value. kind 0 loads a pair of vector a into the
// store, kind 1 streams a pair of vector b, kind 2 finishes, kind 3 is dropped.
// out: one word per finish with dot product, cosine and flags.
// an a pair is accepted and squared, then accumulated and stored.
// a b pair is accepted and squared, then accumulated, then compared with one
// store entry per merge pointer step, plus one more state on a match; the
// single multiplier does the square on accept and the product during the
// compare, and the store gives one entry a cycle. after a finish is accepted
// the result comes from two square roots, one multiply for the denominator and
// a fraction division; a clamp to one skips the division, a zero norm all.
// the result sits on the output until taken; no new word is accepted meanwhile.
// reset clears all control state and accumulators; the store contents are not
// cleared and entries beyond the fill count are never used.
module sparse_cosine_similarity_unit #(
	parameter int MAX_ENTRIES     = 1024,
	parameter int INDEX_BITS      = 24,
	parameter int VALUE_FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	scs_if.sink   in,
	scs_if.source out
);
	import scs_pkg::*;

	localparam int AW  = $clog2(MAX_ENTRIES);
	localparam int CW  = $clog2(MAX_ENTRIES + 1);
	localparam int SH  = 2 * VALUE_FRAC_BITS - 32;
	localparam int RSH = (SH > 0) ? SH : 0;
	localparam int LSH = (SH < 0) ? -SH : 0;
	localparam logic [IDX_W-1:0] IDX_MASK = (INDEX_BITS >= IDX_W) ? {IDX_W{1'b1}} :
		IDX_W'((64'd1 << INDEX_BITS) - 64'd1);

	in_word_t iw;
	state_t   state_q, state_d;

	logic [IDX_W-1:0]        idx_q;
	logic signed [VAL_W-1:0] val_q;
	logic [CW-1:0]           cnt_q, ptr_q, ptr_nx;
	logic signed [ACC_W-1:0] dot_q, na_q, nb_q;
	logic                    bst_q, ovf_q, ord_q;
	logic signed [32:0]      ma, mb;
	logic signed [65:0]      prod_full;
	logic signed [63:0]      prod_s1;
	logic signed [63:0]      scaled;
	logic                    sc_ovf;
	logic signed [ACC_W-1:0] acc_in, acc_sum;
	logic                    acc_ovf;
	logic                    ram_we;
	logic [AW-1:0]           ram_addr;
	logic [IDX_W-1:0]        ri;
	logic [VAL_W-1:0]        rv;
	logic                    sq_start, sq_done, dv_start, dv_done;
	logic [63:0]             sq_in;
	logic [31:0]             sq_root, sa_q;
	logic [29:0]             dv_frac;
	logic [63:0]             mag, den;
	logic                    zn;
	logic [COS_W-1:0]        cos_q;

	assign iw        = in_word_t'(in.data);
	assign in.ready  = (state_q == ST_IDLE);
	assign out.valid = (state_q == ST_OUT);
	assign out.data  = {dot_q, cos_q, zn, ovf_q, ord_q};

	assign zn     = (na_q == '0) || (nb_q == '0);
	assign mag    = dot_q[ACC_W-1] ? 64'(-dot_q) : 64'(dot_q);
	assign den    = prod_s1;
	assign ptr_nx = ptr_q + CW'(1);

	scs_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES)) u_iram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(idx_q), .rdata(ri));
	scs_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ENTRIES)) u_vram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(val_q), .rdata(rv));

	scs_sqrt u_sqrt (.clk(clk), .arst_n(arst_n), .start(sq_start), .radicand(sq_in),
		.done(sq_done), .root(sq_root));
	scs_div u_div (.clk(clk), .arst_n(arst_n), .start(dv_start), .dividend(mag),
		.divisor(den), .done(dv_done), .quotient(dv_frac));

	// shared multiplier
	always_comb begin
		case (state_q)
			ST_IDLE: begin
				ma = {iw.value[VAL_W-1], iw.value};
				mb = {iw.value[VAL_W-1], iw.value};
			end
			ST_B_CMP: begin
				ma = {rv[VAL_W-1], rv};
				mb = {val_q[VAL_W-1], val_q};
			end
			ST_FIN_MUL: begin
				ma = {1'b0, sa_q};
				mb = {1'b0, sq_root};
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign prod_full = ma * mb;

	always_ff @(posedge clk) begin
		prod_s1 <= prod_full[63:0];
	end

	// scaling to q32.32
	always_comb begin
		scaled = prod_s1 >>> RSH;
		sc_ovf = 1'b0;
		if (LSH > 0) begin
			if (prod_s1 > (S64_MAX >>> LSH)) begin
				scaled = S64_MAX;
				sc_ovf = 1'b1;
			end else if (prod_s1 < -(S64_MAX >>> LSH)) begin
				scaled = S64_MIN;
				sc_ovf = 1'b1;
			end else begin
				scaled = prod_s1 <<< LSH;
			end
		end
	end

	// shared saturating accumulator
	always_comb begin
		case (state_q)
			ST_A_SQ: acc_in = na_q;
			ST_B_SQ: acc_in = nb_q;
			default: acc_in = dot_q;
		endcase
		acc_sum = acc_in + scaled;
		acc_ovf = 1'b0;
		if (scaled > 0 && acc_in > S64_MAX - scaled) begin
			acc_sum = S64_MAX;
			acc_ovf = 1'b1;
		end else if (scaled < 0 && acc_in < S64_MIN - scaled) begin
			acc_sum = S64_MIN;
			acc_ovf = 1'b1;
		end
	end

	always_comb begin
		ram_we   = (state_q == ST_A_SQ);
		case (state_q)
			ST_A_SQ:  ram_addr = cnt_q[AW-1:0];
			ST_B_CMP: ram_addr = ptr_nx[AW-1:0];
			default:  ram_addr = ptr_q[AW-1:0];
		endcase
		sq_start = (state_q == ST_FIN_SQA) || (state_q == ST_FIN_SQB);
		sq_in    = (state_q == ST_FIN_SQB) ? nb_q : na_q;
		dv_start = (state_q == ST_FIN_DEN) && (mag < den);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in.valid) begin
					case (iw.kind)
						KIND_A: begin
							if (!bst_q && cnt_q != CW'(MAX_ENTRIES)) begin
								state_d = ST_A_SQ;
							end
						end
						KIND_B:      state_d = ST_B_SQ;
						KIND_FINISH: state_d = zn ? ST_OUT : ST_FIN_SQA;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_A_SQ:  state_d = ST_IDLE;
			ST_B_SQ:  state_d = (ptr_q < cnt_q) ? ST_B_CMP : ST_IDLE;
			ST_B_CMP: begin
				if (ri < idx_q) begin
					state_d = (ptr_nx < cnt_q) ? ST_B_CMP : ST_IDLE;
				end else if (ri == idx_q) begin
					state_d = ST_B_MUL;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_B_MUL:   state_d = ST_IDLE;
			ST_FIN_SQA: state_d = ST_FIN_WA;
			ST_FIN_WA: begin
				if (sq_done) begin
					state_d = ST_FIN_SQB;
				end
			end
			ST_FIN_SQB: state_d = ST_FIN_WB;
			ST_FIN_WB: begin
				if (sq_done) begin
					state_d = ST_FIN_MUL;
				end
			end
			ST_FIN_MUL: state_d = ST_FIN_DEN;
			ST_FIN_DEN: state_d = (mag < den) ? ST_FIN_DIV : ST_OUT;
			ST_FIN_DIV: begin
				if (dv_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ptr_q <= '0;
			dot_q <= '0;
			na_q  <= '0;
			nb_q  <= '0;
			bst_q <= 1'b0;
			ovf_q <= 1'b0;
			ord_q <= 1'b0;
			idx_q <= '0;
			val_q <= '0;
			sa_q  <= '0;
			cos_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in.valid) begin
						idx_q <= iw.index & IDX_MASK;
						val_q <= iw.value;
						case (iw.kind)
							KIND_A: begin
								if (bst_q) begin
									ord_q <= 1'b1;
								end else if (cnt_q == CW'(MAX_ENTRIES)) begin
									ovf_q <= 1'b1;
								end
							end
							KIND_B:      bst_q <= 1'b1;
							KIND_FINISH: cos_q <= '0;
							default:     ;
						endcase
					end
				end
				ST_A_SQ: begin
					cnt_q <= cnt_q + CW'(1);
					na_q  <= acc_sum;
					ovf_q <= ovf_q | sc_ovf | acc_ovf;
				end
				ST_B_SQ: begin
					nb_q  <= acc_sum;
					ovf_q <= ovf_q | sc_ovf | acc_ovf;
				end
				ST_B_CMP: begin
					if (ri <= idx_q) begin
						ptr_q <= ptr_nx;
					end
				end
				ST_B_MUL: begin
					dot_q <= acc_sum;
					ovf_q <= ovf_q | sc_ovf | acc_ovf;
				end
				ST_FIN_WA: begin
					if (sq_done) begin
						sa_q <= sq_root;
					end
				end
				ST_FIN_DEN: begin
					if (mag >= den) begin
						cos_q <= dot_q[ACC_W-1] ? -COS_ONE : COS_ONE;
					end
				end
				ST_FIN_DIV: begin
					if (dv_done) begin
						cos_q <= dot_q[ACC_W-1] ? -{2'b00, dv_frac} : {2'b00, dv_frac};
					end
				end
				ST_OUT: begin
					if (out.ready) begin
						cnt_q <= '0;
						ptr_q <= '0;
						dot_q <= '0;
						na_q  <= '0;
						nb_q  <= '0;
						bst_q <= 1'b0;
						ovf_q <= 1'b0;
						ord_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

### rtl/scs_ram.sv
// scs_ram: generic single port ram with registered read
// no dependencies
module scs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

### rtl/scs_sqrt.sv
// scs_sqrt: iterative 64-bit integer square root, one result bit a cycle
// depends on scs_pkg
module scs_sqrt (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [63:0]         radicand,
	output logic                done,
	output logic [31:0]         root
);
	import scs_pkg::*;

	logic [63:0] rem_q;
	logic [31:0] root_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [65:0] trial;
	logic [65:0] shifted;
	logic [63:0] radicand_q;

	assign shifted = {rem_q, radicand_q[63:62]};
	assign trial   = {32'd0, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q      <= '0;
			root_q     <= '0;
			radicand_q <= radicand;
		end else if (busy_q) begin
			radicand_q <= {radicand_q[61:0], 2'b00};
			if (shifted >= trial) begin
				rem_q  <= 64'(shifted - trial);
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q  <= shifted[63:0];
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end

	assign root = root_q;
endmodule

### rtl/scs_div.sv
// scs_div: restoring divider for a proper fraction, 30 quotient bits, one a cycle
// no dependencies
module scs_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        done,
	output logic [29:0] quotient
);
	logic [29:0] q_q;
	logic [63:0] r_q;
	logic [63:0] d_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [64:0] sh;
	logic [64:0] diff;

	assign sh   = {r_q, 1'b0};
	assign diff = sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd30;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= '0;
			r_q <= dividend;
			d_q <= divisor;
		end else if (busy_q) begin
			if (sh >= {1'b0, d_q}) begin
				r_q <= diff[63:0];
				q_q <= {q_q[28:0], 1'b1};
			end else begin
				r_q <= sh[63:0];
				q_q <= {q_q[28:0], 1'b0};
			end
		end
	end

	assign quotient = q_q;
endmodule

### tb/sv/sparse_cosine_similarity_unit_test.sv
// sparse_cosine_similarity_unit_test: self-checking bench for the sparse cosine similarity unit
// streams vector pairs and finishes, predicts dot product, cosine and flags in place
// depends on scs_pkg, scs_if, sparse_cosine_similarity_unit
module sparse_cosine_similarity_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import scs_pkg::*;

	localparam int DEPTH = 1024;
	localparam int IN_W = $bits(in_word_t);
	localparam int OUT_W = $bits(out_word_t);
	localparam logic [63:0] MAX64 = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	scs_if #(.W(IN_W)) in_ch (clk);
	scs_if #(.W(OUT_W)) out_ch (clk);

	sparse_cosine_similarity_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in(in_ch.sink),
		.out(out_ch.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [23:0] vec_a_idx [DEPTH];
	logic signed [31:0] vec_a_val [DEPTH];
	int unsigned a_fill, merge_ptr;
	logic signed [63:0] dot_acc, norm_a, norm_b;
	bit b_seen, sat_flag, order_flag;

	in_word_t word_q[$];
	out_word_t result_q[$];
	int errors;
	int send_idle, recv_idle, hold_cycles;

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic logic signed [63:0] sat_sum(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s > $signed({1'b0, MAX64})) begin
			sat_flag = 1;
			return MAX64;
		end
		if (s < $signed({1'b1, MIN64})) begin
			sat_flag = 1;
			return MIN64;
		end
		return s[63:0];
	endfunction

	function automatic logic [63:0] root64(input logic [63:0] n);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Q16.16 squared/product has 32 fraction bits already: Q32.32 directly
	function automatic void predict(input in_word_t w);
		logic signed [31:0] v;
		logic signed [63:0] p;
		logic [63:0] sa, sb, den, mag, q, r;
		logic [31:0] cos_v;
		out_word_t res;
		bit zn, neg;
		v = w.value;
		p = 64'(v) * 64'(v);
		case (kind_t'(w.kind))
			KIND_A: begin
				if (b_seen) order_flag = 1;
				else if (a_fill >= DEPTH) sat_flag = 1;
				else begin
					vec_a_idx[a_fill] = w.index;
					vec_a_val[a_fill] = v;
					a_fill++;
					norm_a = sat_sum(norm_a, p);
				end
			end
			KIND_B: begin
				b_seen = 1;
				norm_b = sat_sum(norm_b, p);
				while (merge_ptr < a_fill && vec_a_idx[merge_ptr] < w.index) merge_ptr++;
				if (merge_ptr < a_fill && vec_a_idx[merge_ptr] == w.index) begin
					dot_acc = sat_sum(dot_acc, 64'(vec_a_val[merge_ptr]) * 64'(v));
					merge_ptr++;
				end
			end
			KIND_FINISH: begin
				zn = norm_a == 0 || norm_b == 0;
				neg = dot_acc < 0;
				cos_v = '0;
				if (!zn) begin
					sa = root64(norm_a);
					sb = root64(norm_b);
					den = sa * sb;
					mag = neg ? -dot_acc : dot_acc;
					q = mag / den;
					r = mag % den;
					if (q > 1) q = 64'd1 << 30;
					else begin
						for (int i = 0; i < 30; i++) begin
							r <<= 1;
							q <<= 1;
							if (r >= den) begin
								r -= den;
								q |= 1;
							end
						end
						if (q > (64'd1 << 30)) q = 64'd1 << 30;
					end
					cos_v = neg ? -q[31:0] : q[31:0];
				end
				res.dot_product = dot_acc;
				res.cosine = cos_v;
				res.zero_norm = zn;
				res.overflow = sat_flag;
				res.order_error = order_flag;
				result_q.push_back(res);
				a_fill = 0;
				merge_ptr = 0;
				dot_acc = 0;
				norm_a = 0;
				norm_b = 0;
				b_seen = 0;
				sat_flag = 0;
				order_flag = 0;
			end
			default: ;
		endcase
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				predict(in_word_t'(in_ch.data));
				void'(word_q.pop_front());
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (word_q.size() > 0 && $urandom_range(99) >= send_idle) begin
					in_ch.valid <= 1'b1;
					in_ch.data <= word_q[0];
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold, counted down
	always @(posedge clk) begin
		if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				out_word_t got, want;
				got = out_ch.data;
				if (result_q.size() == 0) begin
					report("unexpected word", got.dot_product, 0);
				end else begin
					want = result_q.pop_front();
					if (got.dot_product !== want.dot_product)
						report("dot_product", got.dot_product, want.dot_product);
					if (got.cosine !== want.cosine)
						report("cosine", got.cosine, want.cosine);
					if (got.zero_norm !== want.zero_norm)
						report("zero_norm", got.zero_norm, want.zero_norm);
					if (got.overflow !== want.overflow)
						report("overflow", got.overflow, want.overflow);
					if (got.order_error !== want.order_error)
						report("order_error", got.order_error, want.order_error);
				end
			end
			if (hold_cycles > 0) begin
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= $urandom_range(99) >= recv_idle;
			end
		end
	end

	function automatic in_word_t mk(input kind_t k, input logic [23:0] i,
			input logic [31:0] v);
		in_word_t w;
		w.kind = k;
		w.index = i;
		w.value = v;
		return w;
	endfunction

	function automatic logic [31:0] rand_val();
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'h8000_0000 | $urandom_range(3);
			2: return 32'h7fff_ffff - $urandom_range(3);
			default: return 32'($signed($urandom_range(600000)) - 300000);
		endcase
	endfunction

	// one pair of sparse vectors with ascending indices and a finish, plus random stray words when noisy
	task automatic queue_vectors(input int n_a, input int n_b, input bit noisy);
		logic [23:0] ia, ib;
		ia = 24'($urandom_range(3));
		ib = 24'($urandom_range(3));
		for (int i = 0; i < n_a; i++) begin
			word_q.push_back(mk(KIND_A, ia, rand_val()));
			ia += 24'(1 + $urandom_range(2));
		end
		for (int i = 0; i < n_b; i++) begin
			if (noisy && $urandom_range(9) == 0)
				word_q.push_back(mk(kind_t'($urandom_range(3)), 24'($urandom), $urandom));
			word_q.push_back(mk(KIND_B, ib, rand_val()));
			ib += 24'(1 + $urandom_range(2));
		end
		word_q.push_back(mk(KIND_FINISH, 24'($urandom), $urandom));
	endtask

	task automatic drain();
		while (word_q.size() != 0 || in_ch.valid || result_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	initial begin
		errors = 0;
		send_idle = 0;
		recv_idle = 0;
		hold_cycles = 0;
		a_fill = 0;
		merge_ptr = 0;
		dot_acc = 0;
		norm_a = 0;
		norm_b = 0;
		b_seen = 0;
		sat_flag = 0;
		order_flag = 0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, zero norm, order error, unused kind, saturation
		word_q.push_back(mk(KIND_FINISH, 24'hffffff, 32'hffffffff));
		word_q.push_back(mk(KIND_A, 24'd0, 32'h8000_0000));
		word_q.push_back(mk(KIND_A, 24'hffffff, 32'h7fff_ffff));
		word_q.push_back(mk(KIND_NONE, 24'd5, 32'd5));
		word_q.push_back(mk(KIND_B, 24'd0, 32'h8000_0000));
		word_q.push_back(mk(KIND_A, 24'd7, 32'h0001_0000));
		word_q.push_back(mk(KIND_B, 24'hffffff, 32'h8000_0001));
		word_q.push_back(mk(KIND_FINISH, 24'd0, 32'd0));
		word_q.push_back(mk(KIND_A, 24'd3, 32'h0001_0000));
		word_q.push_back(mk(KIND_FINISH, 24'd0, 32'd0));
		word_q.push_back(mk(KIND_A, 24'd5, 32'hfffe_0000));
		word_q.push_back(mk(KIND_A, 24'd2, 32'h0003_0000));
		word_q.push_back(mk(KIND_B, 24'd5, 32'h0004_0000));
		word_q.push_back(mk(KIND_B, 24'd2, 32'h0001_0000));
		word_q.push_back(mk(KIND_FINISH, 24'd0, 32'd0));
		for (int i = 0; i < 4; i++) word_q.push_back(mk(KIND_A, 24'(i), 32'h7fff_ffff));
		for (int i = 0; i < 4; i++) word_q.push_back(mk(KIND_B, 24'(i), 32'h7fff_ffff));
		word_q.push_back(mk(KIND_FINISH, 24'd0, 32'd0));
		drain();

		// store full: fill beyond capacity
		for (int i = 0; i < DEPTH + 2; i++) word_q.push_back(mk(KIND_A, 24'(i), 32'h100));
		word_q.push_back(mk(KIND_B, 24'(DEPTH - 1), 32'h100));
		word_q.push_back(mk(KIND_FINISH, 24'd0, 32'd0));
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle = ph == 1 ? 81 : (ph == 3 ? 21 : 0);
			recv_idle = ph == 2 ? 81 : (ph == 3 ? 21 : 0);
			if (ph == 0) hold_cycles = 3000;
			for (int s = 0; s < 8; s++)
				queue_vectors($urandom_range(8), $urandom_range(8), 1);
			if (ph == 0) begin
				while (word_q.size() != 0 || in_ch.valid) @(posedge clk);
				while (result_q.size() != 0) @(posedge clk);
			end
			drain();
		end
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

### sparse_cosine_similarity_unit.f
rtl/scs_pkg.sv
rtl/scs_if.sv
rtl/scs_ram.sv
rtl/scs_sqrt.sv
rtl/scs_div.sv
rtl/sparse_cosine_similarity_unit.sv
tb/sv/sparse_cosine_similarity_unit_test.sv
